// ===== hdl/jcd_pkg.sv =====
// Shared types, codes and tables of the JPEG coefficient decoder.
`timescale 1ns / 1ps

package jcd_pkg;

  localparam int NUM_COMPONENTS_DEF   = 4;
  localparam int NUM_QUANT_TABLES_DEF = 4;
  localparam int FIFO_DEPTH           = 4;
  localparam int NUM_CFG_REGS         = 4;

  localparam logic [6:0] BLOCK_CLOSED = 7'd64;
  localparam logic [6:0] LAST_ZZ      = 7'd63;
  localparam logic [7:0] SYM_EOB      = 8'h00;
  localparam logic [7:0] SYM_ZRL      = 8'hF0;
  localparam logic [7:0] DC_SIZE_MAX  = 8'd15;

  typedef enum logic [1:0] {
    OP_DC      = 2'd0,
    OP_AC      = 2'd1,
    OP_RESTART = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DC_SIZE = 2'd1,
    STATUS_POS     = 2'd2
  } status_t;

  typedef struct packed {
    logic [5:0]         position;
    logic signed [15:0] value;
    logic [7:0]         quant;
    logic               use_quant;
    logic [1:0]         component;
    logic               block_end;
    status_t            status;
  } entry_t;

  localparam logic [5:0] NATURAL_OF_ZZ [64] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

endpackage

// ===== hdl/jcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module jcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/jcd_front.sv =====
// Front end: accepts symbols, tracks predictors and block index, loads and reads the quant table.
`timescale 1ns / 1ps

module jcd_front #(
  parameter int NUM_COMPONENTS   = jcd_pkg::NUM_COMPONENTS_DEF,
  parameter int NUM_QUANT_TABLES = jcd_pkg::NUM_QUANT_TABLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [1:0]      cfg_data,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,
  input  logic [1:0]      in_tuser,
  output logic            push,
  output jcd_pkg::entry_t push_data,
  input  logic            fifo_full
);

  localparam int QDEPTH = NUM_QUANT_TABLES * 64;
  localparam int QAW    = $clog2(QDEPTH);

  jcd_pkg::op_t op;
  logic [1:0]   comp;
  logic [7:0]   sym;
  logic [14:0]  extra;
  logic [1:0]   load_table;
  logic [5:0]   load_pos;
  logic [7:0]   load_value;

  logic [1:0]         quant_sel_r [jcd_pkg::NUM_CFG_REGS];
  logic [6:0]         ci_r, ci_nxt;
  logic signed [15:0] pred_r [NUM_COMPONENTS];
  logic signed [15:0] pred_nxt [NUM_COMPONENTS];

  logic               f1_valid_r, f1_valid_nxt;
  logic [5:0]         f1_pos_r;
  logic signed [15:0] f1_val_r;
  logic               f1_useq_r;
  logic [1:0]         f1_comp_r;
  logic               f1_end_r;
  jcd_pkg::status_t   f1_status_r;

  logic               accept;
  logic               comp_ok;
  logic [1:0]         tsel;
  logic signed [15:0] pred_cur;
  logic signed [15:0] ext_val;
  logic signed [15:0] pred_sum;
  logic [6:0]         k_eob, k_zrl, k_run;
  logic               emit;
  logic [5:0]         e_pos;
  logic signed [15:0] e_val;
  logic               e_useq;
  logic               e_end;
  jcd_pkg::status_t   e_status;
  logic               rd_en;
  logic [5:0]         rd_zz;
  logic               wr_en;
  logic [7:0]         q_data;

  function automatic logic signed [15:0] extend_bits(input logic [14:0] raw,
                                                     input logic [3:0] size);
    logic [16:0] span;
    logic [16:0] v;
    logic [16:0] r;
    span = 17'd1 << size;
    v    = {2'b00, raw} & (span - 17'd1);
    if (size == 4'd0) begin
      r = 17'd0;
    end else if (v < (span >> 1)) begin
      r = v - span + 17'd1;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

  assign op         = jcd_pkg::op_t'(in_tuser);
  assign comp       = in_tdata[1:0];
  assign sym        = in_tdata[9:2];
  assign extra      = in_tdata[24:10];
  assign load_table = in_tdata[26:25];
  assign load_pos   = in_tdata[32:27];
  assign load_value = in_tdata[40:33];

  assign in_tready = !f1_valid_r || !fifo_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = f1_valid_r && !fifo_full;
  assign comp_ok   = (32'(comp) < NUM_COMPONENTS);

  always_comb begin
    tsel = quant_sel_r[comp];
    if (32'(tsel) >= NUM_QUANT_TABLES) begin
      tsel = 2'(NUM_QUANT_TABLES - 1);
    end
  end

  always_comb begin
    pred_cur = '0;
    for (int i = 0; i < NUM_COMPONENTS; i++) begin
      if (32'(comp) == i) begin
        pred_cur = pred_r[i];
      end
    end
  end

  assign ext_val  = extend_bits(extra, sym[3:0]);
  assign pred_sum = pred_cur + ext_val;
  assign k_eob    = ci_r + 7'd1;
  assign k_zrl    = ci_r + 7'd16;
  assign k_run    = ci_r + 7'd1 + {3'b000, sym[7:4]};

  always_comb begin
    ci_nxt   = ci_r;
    pred_nxt = pred_r;
    emit     = 1'b0;
    e_pos    = '0;
    e_val    = '0;
    e_useq   = 1'b0;
    e_end    = 1'b0;
    e_status = jcd_pkg::STATUS_OK;
    rd_en    = 1'b0;
    rd_zz    = '0;
    wr_en    = 1'b0;
    if (accept) begin
      case (op)
        jcd_pkg::OP_RESTART: begin
          ci_nxt = '0;
          for (int i = 0; i < NUM_COMPONENTS; i++) begin
            pred_nxt[i] = '0;
          end
        end
        jcd_pkg::OP_LOAD: begin
          wr_en = (32'(load_table) < NUM_QUANT_TABLES);
        end
        jcd_pkg::OP_DC: begin
          if (comp_ok) begin
            emit = 1'b1;
            if (sym > jcd_pkg::DC_SIZE_MAX) begin
              ci_nxt   = jcd_pkg::BLOCK_CLOSED;
              e_end    = 1'b1;
              e_status = jcd_pkg::STATUS_DC_SIZE;
            end else begin
              ci_nxt = '0;
              for (int i = 0; i < NUM_COMPONENTS; i++) begin
                if (32'(comp) == i) begin
                  pred_nxt[i] = pred_sum;
                end
              end
              e_val  = pred_sum;
              e_useq = 1'b1;
              rd_en  = 1'b1;
            end
          end
        end
        default: begin
          if (comp_ok) begin
            if (ci_r >= jcd_pkg::LAST_ZZ) begin
              emit     = 1'b1;
              ci_nxt   = jcd_pkg::BLOCK_CLOSED;
              e_end    = 1'b1;
              e_status = jcd_pkg::STATUS_POS;
            end else if (sym == jcd_pkg::SYM_EOB) begin
              emit   = 1'b1;
              ci_nxt = jcd_pkg::BLOCK_CLOSED;
              e_pos  = jcd_pkg::NATURAL_OF_ZZ[k_eob[5:0]];
              e_end  = 1'b1;
            end else if (sym == jcd_pkg::SYM_ZRL) begin
              if (k_zrl < jcd_pkg::LAST_ZZ) begin
                ci_nxt = k_zrl;
              end else begin
                emit   = 1'b1;
                ci_nxt = jcd_pkg::BLOCK_CLOSED;
                e_end  = 1'b1;
                if (k_zrl == jcd_pkg::LAST_ZZ) begin
                  e_pos = jcd_pkg::NATURAL_OF_ZZ[k_zrl[5:0]];
                end else begin
                  e_status = jcd_pkg::STATUS_POS;
                end
              end
            end else if (k_run > jcd_pkg::LAST_ZZ) begin
              emit     = 1'b1;
              ci_nxt   = jcd_pkg::BLOCK_CLOSED;
              e_end    = 1'b1;
              e_status = jcd_pkg::STATUS_POS;
            end else begin
              emit   = 1'b1;
              e_pos  = jcd_pkg::NATURAL_OF_ZZ[k_run[5:0]];
              e_val  = ext_val;
              e_useq = 1'b1;
              rd_en  = 1'b1;
              rd_zz  = k_run[5:0];
              if (k_run == jcd_pkg::LAST_ZZ) begin
                ci_nxt = jcd_pkg::BLOCK_CLOSED;
                e_end  = 1'b1;
              end else begin
                ci_nxt = k_run;
              end
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    f1_valid_nxt = f1_valid_r;
    if (accept) begin
      f1_valid_nxt = emit;
    end else if (push) begin
      f1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_r       <= '0;
      f1_valid_r <= 1'b0;
      for (int i = 0; i < jcd_pkg::NUM_CFG_REGS; i++) begin
        quant_sel_r[i] <= '0;
      end
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
    end else begin
      ci_r       <= ci_nxt;
      f1_valid_r <= f1_valid_nxt;
      pred_r     <= pred_nxt;
      if (cfg_we) begin
        quant_sel_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      f1_pos_r    <= e_pos;
      f1_val_r    <= e_val;
      f1_useq_r   <= e_useq;
      f1_comp_r   <= comp;
      f1_end_r    <= e_end;
      f1_status_r <= e_status;
    end
  end

  jcd_ram #(
    .WIDTH (8),
    .DEPTH (QDEPTH)
  ) u_quant_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (QAW'({load_table, load_pos})),
    .wr_data (load_value),
    .rd_en   (rd_en),
    .rd_addr (QAW'({tsel, rd_zz})),
    .rd_data (q_data)
  );

  always_comb begin
    push_data.position  = f1_pos_r;
    push_data.value     = f1_val_r;
    push_data.quant     = q_data;
    push_data.use_quant = f1_useq_r;
    push_data.component = f1_comp_r;
    push_data.block_end = f1_end_r;
    push_data.status    = f1_status_r;
  end

endmodule

// ===== hdl/jcd_fifo.sv =====
// Short request queue between the front end and the multiply back end.
`timescale 1ns / 1ps

module jcd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jcd_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output jcd_pkg::entry_t pop_data
);

  localparam int PTR_W = $clog2(jcd_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(jcd_pkg::FIFO_DEPTH + 1);

  jcd_pkg::entry_t  mem_r [jcd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(jcd_pkg::FIFO_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == jcd_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == jcd_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/jcd_back.sv =====
// Back end: dequantizing multiply and the output register of the result stream.
`timescale 1ns / 1ps

module jcd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            entry_valid,
  input  jcd_pkg::entry_t entry,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata,
  output logic            out_tlast,
  output logic [1:0]      out_tuser
);

  logic               out_valid_r, out_valid_nxt;
  logic [5:0]         pos_r;
  logic signed [23:0] coef_r;
  logic [1:0]         comp_r;
  logic               end_r;
  logic [1:0]         status_r;
  logic signed [23:0] product;
  logic signed [23:0] coef;

  assign pop     = entry_valid && (!out_valid_r || out_tready);
  assign product = 24'(entry.value) * 24'($signed({1'b0, entry.quant}));
  assign coef    = entry.use_quant ? product : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pos_r    <= entry.position;
      coef_r   <= coef;
      comp_r   <= entry.component;
      end_r    <= entry.block_end;
      status_r <= entry.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {comp_r, coef_r, pos_r};
  assign out_tlast  = end_r;
  assign out_tuser  = status_r;

endmodule

// ===== hdl/jpeg_coefficient_decode.sv =====
// Top level of the baseline JPEG coefficient decoder.
//
// Channel  Dir  Handshake            Content
// in_      in   tvalid/tready        tuser op, tdata symbol, extra bits, quant load
// out_     out  tvalid/tready        tdata position/coefficient/component, tlast, tuser status
// cfg_     in   cfg_we               quant table select of each component
//
// One request is accepted per cycle while the queue has room or the front stage is empty; a
// result reaches out_ through the quant RAM read stage, the queue and the output register, with
// the multiply in front of the output register.
// Synchronous active-low reset clears predictors, block index, selects and the queue;
// quant table contents are not cleared and need no clearing pass.
// A four-entry queue lets the front end keep accepting while the output is stalled.
`timescale 1ns / 1ps

module jpeg_coefficient_decode #(
  parameter int NUM_COMPONENTS   = jcd_pkg::NUM_COMPONENTS_DEF,
  parameter int NUM_QUANT_TABLES = jcd_pkg::NUM_QUANT_TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // component, symbol, extra_bits, load_table, load_pos, load_value, zero fill
  input  logic [47:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // position, coefficient, out_component
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  // status
  output logic [1:0]  out_tuser
);

  logic            push;
  jcd_pkg::entry_t push_data;
  logic            fifo_full;
  logic            pop;
  logic            fifo_valid;
  jcd_pkg::entry_t pop_data;

  jcd_front #(
    .NUM_COMPONENTS   (NUM_COMPONENTS),
    .NUM_QUANT_TABLES (NUM_QUANT_TABLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_data (push_data),
    .fifo_full (fifo_full)
  );

  jcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .valid     (fifo_valid),
    .pop_data  (pop_data)
  );

  jcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (fifo_valid),
    .entry       (pop_data),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
